@@ sv/kmd_pkg.sv @@
package kmd_pkg;

    localparam int TIME_W = 32;
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic [1:0] CFG_ROOT_KEY = 2'd0;
    localparam logic [1:0] CFG_CHAN_NUM = 2'd1;
    localparam logic [1:0] CFG_VEL_BYTE = 2'd2;
    localparam logic [1:0] CFG_HOLD_MS  = 2'd3;

    localparam logic [6:0]  ROOT_KEY_RST = 7'd36;
    localparam logic [4:0]  CHAN_NUM_RST = 5'd1;
    localparam logic [6:0]  VEL_BYTE_RST = 7'd100;
    localparam logic [15:0] HOLD_MS_RST  = 16'd20;

    localparam logic [3:0] CIN_NOTE_ON  = 4'h9;
    localparam logic [3:0] CIN_NOTE_OFF = 4'h8;
    localparam logic [7:0] ST_NOTE_ON   = 8'h90;
    localparam logic [7:0] ST_NOTE_OFF  = 8'h80;
    localparam logic [3:0] CHAN_MASK    = 4'hF;

    typedef struct packed {
        logic [2:0]        row;
        logic [2:0]        col;
        logic              pressed;
        logic [TIME_W-1:0] now_ms;
    } kmd_in_t;

    typedef struct packed {
        logic [3:0] code_index;
        logic [7:0] status;
        logic [7:0] note;
        logic [6:0] velocity;
    } kmd_out_t;

    typedef struct packed {
        logic [6:0]  root_key;
        logic [4:0]  chan_num;
        logic [6:0]  vel_byte;
        logic [15:0] hold_ms;
    } kmd_cfg_t;

endpackage

@@ sv/kmd_ram.sv @@
module kmd_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 64
) (
    input  logic                                 aclk,
    input  logic                                 wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                     wr_data,
    input  logic                                 rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                     rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/kmd_front.sv @@
module kmd_front import kmd_pkg::*; #(
    parameter int ROWS = 8,
    parameter int COLS = 8
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  kmd_in_t                 s_data,
    output logic                    push,
    output logic [((ROWS * COLS) > 1 ? $clog2(ROWS * COLS) : 1) + TIME_W:0] push_data,
    input  logic                    q_full
);

    localparam int DEPTH = ROWS * COLS;
    localparam int KW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int QW    = KW + 1 + TIME_W;

    logic          f_valid_reg, f_valid_next;
    logic [QW-1:0] f_data_reg;
    logic          in_range;
    logic [7:0]    key_full;
    logic          take;

    assign in_range = (5'(s_data.row) < 5'(ROWS)) && (5'(s_data.col) < 5'(COLS));
    assign key_full = 8'(s_data.row) * 8'(COLS) + 8'(s_data.col);

    assign push    = f_valid_reg && !q_full;
    assign s_ready = !f_valid_reg || !q_full;
    assign take    = s_valid && s_ready && in_range;

    always_comb begin
        f_valid_next = f_valid_reg;
        if (push) begin
            f_valid_next = 1'b0;
        end
        if (take) begin
            f_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            f_data_reg <= {KW'(key_full), s_data.pressed, s_data.now_ms};
        end
    end

    assign push_data = f_data_reg;

endmodule

@@ sv/kmd_fifo.sv @@
module kmd_fifo import kmd_pkg::*; #(
    parameter int WIDTH = 39
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] head
);

    logic [WIDTH-1:0] buf_reg [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QAW:0]     cnt_reg, cnt_next;

    assign full      = (cnt_reg == (QAW+1)'(QDEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = buf_reg[rd_ptr_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ sv/kmd_back.sv @@
module kmd_back import kmd_pkg::*; #(
    parameter int ROWS = 8,
    parameter int COLS = 8
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  kmd_cfg_t cfg,
    input  logic     q_valid,
    input  logic [((ROWS * COLS) > 1 ? $clog2(ROWS * COLS) : 1) + TIME_W:0] q_data,
    output logic     q_pop,
    output logic     m_valid,
    input  logic     m_ready,
    output kmd_out_t m_data
);

    localparam int DEPTH = ROWS * COLS;
    localparam int KW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int SW    = TIME_W + 2;

    logic [KW-1:0]     q_key;
    logic [DEPTH-1:0]  vld_reg;

    logic              x_valid_reg;
    logic [KW-1:0]     x_key_reg;
    logic              x_lvl_reg;
    logic [TIME_W-1:0] x_now_reg;
    logic              x_vld_reg;
    logic              fwd_reg;
    logic [SW-1:0]     fwd_data_reg;

    logic [SW-1:0]     rd_data;
    logic [SW-1:0]     x_state;
    logic              st_deb, st_raw;
    logic [TIME_W-1:0] st_time;
    logic [TIME_W-1:0] held;
    logic              x_fire;
    logic              x_retire;
    logic [SW-1:0]     wr_data;
    logic              out_free;

    logic              out_valid_reg;
    kmd_out_t          out_data_reg, out_data_next;
    logic [3:0]        chan;

    assign q_key = q_data[KW+TIME_W -: KW];

    assign x_state = fwd_reg ? fwd_data_reg : (x_vld_reg ? rd_data : '0);
    assign st_deb  = x_state[SW-1];
    assign st_raw  = x_state[SW-2];
    assign st_time = x_state[TIME_W-1:0];
    assign held    = x_now_reg - st_time;

    always_comb begin
        if (x_lvl_reg != st_raw) begin
            x_fire  = 1'b0;
            wr_data = {st_deb, x_lvl_reg, x_now_reg};
        end else begin
            x_fire  = (held > TIME_W'(cfg.hold_ms)) && (st_deb != x_lvl_reg);
            wr_data = {(x_fire ? x_lvl_reg : st_deb), st_raw, st_time};
        end
    end

    assign out_free = !out_valid_reg || m_ready;
    assign x_retire = x_valid_reg && (!x_fire || out_free);
    assign q_pop    = q_valid && (!x_valid_reg || x_retire);

    kmd_ram #(
        .WIDTH (SW),
        .DEPTH (DEPTH)
    ) u_state_ram (
        .aclk    (aclk),
        .wr_en   (x_retire),
        .wr_addr (x_key_reg),
        .wr_data (wr_data),
        .rd_en   (q_pop),
        .rd_addr (q_key),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_valid_reg <= 1'b0;
            vld_reg     <= '0;
        end else begin
            if (q_pop) begin
                x_valid_reg <= 1'b1;
            end else if (x_retire) begin
                x_valid_reg <= 1'b0;
            end
            if (x_retire) begin
                vld_reg[x_key_reg] <= 1'b1;
            end
        end
    end

    // forward the retiring write when the next item hits the same key
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            x_key_reg    <= q_key;
            x_lvl_reg    <= q_data[TIME_W];
            x_now_reg    <= q_data[TIME_W-1:0];
            x_vld_reg    <= vld_reg[q_key];
            fwd_reg      <= x_valid_reg && (x_key_reg == q_key);
            fwd_data_reg <= wr_data;
        end
    end

    assign chan = 4'(cfg.chan_num - 5'd1) & CHAN_MASK;

    always_comb begin
        out_data_next.code_index = x_lvl_reg ? CIN_NOTE_ON : CIN_NOTE_OFF;
        out_data_next.status     = (x_lvl_reg ? ST_NOTE_ON : ST_NOTE_OFF) | {4'h0, chan};
        out_data_next.note       = 8'(cfg.root_key) + 8'(x_key_reg);
        out_data_next.velocity   = cfg.vel_byte;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            if (x_retire && x_fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (x_retire && x_fire) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

`ifndef SYNTHESIS
    a_pop_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> x_valid_reg)
        else $error("popped item not loaded into execute stage");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        x_valid_reg && !x_retire |=> x_valid_reg && $stable(x_key_reg) && $stable(x_now_reg))
        else $error("stalled execute item changed");

    a_fire_out: assert property (@(posedge aclk) disable iff (!aresetn)
        x_retire && x_fire |=> out_valid_reg)
        else $error("note event lost");

    a_fwd_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        fwd_reg && x_valid_reg && $past(q_pop) |-> $past(x_retire))
        else $error("forwarded state from an item that did not retire");
`endif

endmodule

@@ sv/key_matrix_debounce_note_events_core.sv @@
// Channel | Ports                             | Moves
// input   | s_valid s_ready s_data (kmd_in_t)  | one raw key sample
// output  | m_valid m_ready m_data (kmd_out_t) | one note on / note off packet
// config  | cfg_wr_en cfg_index cfg_data       | register write, no wait
//
// One key sample per cycle sustained while the output is not stalled; m_valid is driven
// by the output register behind the input register, queue and update stage. The rate is set
// by the registered state RAM read and the update stage; a same-key update is forwarded so
// back-to-back samples never wait. Reset clears all per-key state at once through valid bits;
// no clearing pass. An output stall backs requests up through the update stage, the 4-entry
// queue and the input register before s_ready drops.
module key_matrix_debounce_note_events_core import kmd_pkg::*; #(
    parameter int ROWS = 8,
    parameter int COLS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  kmd_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output kmd_out_t    m_data,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int DEPTH = ROWS * COLS;
    localparam int KW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int QW    = KW + 1 + TIME_W;

    kmd_cfg_t      cfg_reg;
    logic          push, q_full, q_pop, q_valid;
    logic [QW-1:0] push_data, q_head;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.root_key <= ROOT_KEY_RST;
            cfg_reg.chan_num <= CHAN_NUM_RST;
            cfg_reg.vel_byte <= VEL_BYTE_RST;
            cfg_reg.hold_ms  <= HOLD_MS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_ROOT_KEY: cfg_reg.root_key <= cfg_data[6:0];
                CFG_CHAN_NUM: cfg_reg.chan_num <= cfg_data[4:0];
                CFG_VEL_BYTE: cfg_reg.vel_byte <= cfg_data[6:0];
                CFG_HOLD_MS:  cfg_reg.hold_ms  <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    kmd_front #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .push      (push),
        .push_data (push_data),
        .q_full    (q_full)
    );

    kmd_fifo #(
        .WIDTH (QW)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (q_head)
    );

    kmd_back #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_data  (q_head),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

@@ dv/tb_key_matrix_debounce_note_events_core.sv @@
module tb_key_matrix_debounce_note_events_core import kmd_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int KEY_ROWS     = 8;
    localparam int KEY_COLS     = 8;
    localparam int NUM_KEYS     = KEY_ROWS * KEY_COLS;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 170;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed {
        bit          is_write;
        logic [1:0]  reg_idx;
        logic [15:0] reg_val;
        kmd_in_t     smp;
        bit          typed;
        bit          has_note;
        kmd_out_t    note;
    } dir_step_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    kmd_in_t     s_data;
    logic        m_valid;
    logic        m_ready;
    kmd_out_t    m_data;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    logic        pin_on;
    logic        pin_has;
    kmd_out_t    pin_pkt;
    logic        hold_arm;

    bit          key_debounced [NUM_KEYS];
    bit          key_raw [NUM_KEYS];
    bit   [31:0] key_changed_ms [NUM_KEYS];
    logic [6:0]  root_key_r;
    logic [4:0]  chan_num_r;
    logic [6:0]  velocity_r;
    logic [15:0] debounce_r;

    kmd_out_t    pending_notes [$];
    int unsigned fail_cnt;
    int unsigned sent_cnt;
    int unsigned note_cnt;
    int unsigned setting_cnt;
    int unsigned cyc_cnt;
    int unsigned burst_left;

    int unsigned rx_seg_left;
    int unsigned rx_hold_left;
    logic [1:0]  rx_mode;
    bit          rx_hold_done;

    key_matrix_debounce_note_events_core #(
        .ROWS(KEY_ROWS),
        .COLS(KEY_COLS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic kmd_in_t key_sample(input int row, input int col, input bit lvl,
                                           input logic [31:0] t);
        kmd_in_t smp;
        logic [31:0] r32;
        logic [31:0] c32;
        r32 = row;
        c32 = col;
        smp.row     = r32[2:0];
        smp.col     = c32[2:0];
        smp.pressed = lvl;
        smp.now_ms  = t;
        return smp;
    endfunction

    function automatic dir_step_t cfg_step(input logic [1:0] idx, input logic [15:0] val);
        dir_step_t st;
        st = '0;
        st.is_write = 1'b1;
        st.reg_idx  = idx;
        st.reg_val  = val;
        return st;
    endfunction

    function automatic dir_step_t sample_step(input int row, input int col, input bit lvl,
                                              input logic [31:0] t);
        dir_step_t st;
        st = '0;
        st.smp = key_sample(row, col, lvl, t);
        return st;
    endfunction

    function automatic dir_step_t typed_step(input int row, input int col, input bit lvl,
                                             input logic [31:0] t, input bit has,
                                             input kmd_out_t pkt);
        dir_step_t st;
        st = sample_step(row, col, lvl, t);
        st.typed    = 1'b1;
        st.has_note = has;
        st.note     = pkt;
        return st;
    endfunction

    function automatic bit predict_note_event(input kmd_in_t smp, output kmd_out_t pkt);
        int unsigned key;
        logic [31:0] held;
        logic [4:0]  chan_m1;
        logic [31:0] nsum;
        pkt = '0;
        if (smp.row >= KEY_ROWS || smp.col >= KEY_COLS)
            return 1'b0;
        key = smp.row * KEY_COLS + smp.col;
        if (smp.pressed != key_raw[key]) begin
            key_raw[key]        = smp.pressed;
            key_changed_ms[key] = smp.now_ms;
            return 1'b0;
        end
        held = smp.now_ms - key_changed_ms[key];
        if (held <= {16'h0000, debounce_r} || key_debounced[key] == smp.pressed)
            return 1'b0;
        key_debounced[key] = smp.pressed;
        chan_m1 = chan_num_r - 5'd1;
        nsum = root_key_r + key;
        pkt.code_index = smp.pressed ? CIN_NOTE_ON : CIN_NOTE_OFF;
        pkt.status     = (smp.pressed ? ST_NOTE_ON : ST_NOTE_OFF)
                         | {4'h0, chan_m1[3:0] & CHAN_MASK};
        pkt.note       = nsum[7:0];
        pkt.velocity   = velocity_r;
        return 1'b1;
    endfunction

    function automatic void check_field(input string fname, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("note packet %s: expected 0x%0h, got 0x%0h", fname, want, got);
            fail_cnt++;
        end
    endfunction

    always @(posedge aclk) begin : scoreboard
        kmd_out_t want;
        bit hit;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                note_cnt++;
                if (pending_notes.size() == 0) begin
                    $error("note packet with no request waiting: 0x%0h", m_data);
                    fail_cnt++;
                end else begin
                    want = pending_notes.pop_front();
                    check_field("code_index", 32'(want.code_index), 32'(m_data.code_index));
                    check_field("status", 32'(want.status), 32'(m_data.status));
                    check_field("note", 32'(want.note), 32'(m_data.note));
                    check_field("velocity", 32'(want.velocity), 32'(m_data.velocity));
                end
            end
            if (s_valid && s_ready) begin
                hit = predict_note_event(s_data, want);
                if (pin_on) begin
                    hit  = pin_has;
                    want = pin_pkt;
                end
                if (hit)
                    pending_notes.push_back(want);
            end
        end
    end

    always @(posedge aclk) begin
        if (hold_arm && !rx_hold_done) begin
            rx_hold_done <= 1'b1;
            rx_hold_left <= HOLD_CYCLES;
            m_ready      <= 1'b0;
        end else if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
            m_ready      <= (rx_hold_left == 1);
        end else begin
            if (rx_seg_left == 0) begin
                rx_seg_left <= $urandom_range(1, 64);
                rx_mode     <= 2'($urandom_range(0, 2));
            end else begin
                rx_seg_left <= rx_seg_left - 1;
            end
            case (rx_mode)
                2'd0: m_ready <= 1'b1;
                2'd1: m_ready <= 1'($urandom_range(0, 1));
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d packets still expected",
                     cyc_cnt, pending_notes.size());
            $display("tb_key_matrix_debounce_note_events_core failed");
            $finish;
        end
    end

    task automatic send_sample(input kmd_in_t smp, input bit pinned, input bit has,
                               input kmd_out_t pkt);
        int unsigned gap;
        s_valid   <= 1'b1;
        s_data    <= smp;
        pin_on    <= pinned;
        pin_has   <= has;
        pin_pkt   <= pkt;
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_cnt++;
        if (burst_left != 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
            gap = $urandom_range(0, 9);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        case (idx)
            CFG_ROOT_KEY: root_key_r = val[6:0];
            CFG_CHAN_NUM: chan_num_r = val[4:0];
            CFG_VEL_BYTE: velocity_r = val[6:0];
            CFG_HOLD_MS:  debounce_r = val;
            default: ;
        endcase
    endtask

    task automatic settle_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_notes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin : stimulus
        dir_step_t   dir_steps [$];
        kmd_out_t    none_pkt;
        logic [7:0]  st_on_top;
        logic [7:0]  st_off_top;
        logic [31:0] clk_ms;
        logic [31:0] rnd;
        int unsigned dir_cnt;
        int unsigned goal;
        int unsigned pick;
        int          key;
        int          other;
        bit          lvl;
        bit          in_write;

        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        pin_on    = 1'b0;
        pin_has   = 1'b0;
        pin_pkt   = '0;
        hold_arm  = 1'b0;
        none_pkt  = '0;
        root_key_r = ROOT_KEY_RST;
        chan_num_r = CHAN_NUM_RST;
        velocity_r = VEL_BYTE_RST;
        debounce_r = HOLD_MS_RST;
        st_on_top  = ST_NOTE_ON | {4'h0, CHAN_MASK};
        st_off_top = ST_NOTE_OFF | {4'h0, CHAN_MASK};

        dir_steps.push_back(typed_step(0, 0, 1'b1, 32'd1000, 1'b0, none_pkt));
        dir_steps.push_back(typed_step(0, 0, 1'b1, 32'd1020, 1'b0, none_pkt));
        dir_steps.push_back(typed_step(0, 0, 1'b1, 32'd1021, 1'b1,
                            kmd_out_t'{CIN_NOTE_ON, ST_NOTE_ON, 8'd36, 7'd100}));
        dir_steps.push_back(typed_step(7, 7, 1'b1, 32'd5, 1'b0, none_pkt));
        dir_steps.push_back(typed_step(7, 7, 1'b1, 32'd26, 1'b1,
                            kmd_out_t'{CIN_NOTE_ON, ST_NOTE_ON, 8'd99, 7'd100}));
        dir_steps.push_back(typed_step(0, 0, 1'b0, 32'd2000, 1'b0, none_pkt));
        dir_steps.push_back(typed_step(0, 0, 1'b0, 32'd2021, 1'b1,
                            kmd_out_t'{CIN_NOTE_OFF, ST_NOTE_OFF, 8'd36, 7'd100}));
        dir_steps.push_back(typed_step(7, 7, 1'b0, 32'hFFFF_FFF0, 1'b0, none_pkt));
        dir_steps.push_back(typed_step(7, 7, 1'b0, 32'd5, 1'b1,
                            kmd_out_t'{CIN_NOTE_OFF, ST_NOTE_OFF, 8'd99, 7'd100}));
        dir_steps.push_back(sample_step(3, 5, 1'b0, 32'hFFFF_FFFF));
        dir_steps.push_back(sample_step(3, 5, 1'b1, 32'hFFFF_FFFF));
        dir_steps.push_back(sample_step(3, 5, 1'b0, 32'd100));
        dir_steps.push_back(sample_step(3, 5, 1'b1, 32'd200));
        dir_steps.push_back(sample_step(3, 5, 1'b1, 32'd221));
        dir_steps.push_back(cfg_step(CFG_ROOT_KEY, 16'hFFFF));
        dir_steps.push_back(cfg_step(CFG_CHAN_NUM, 16'd16));
        dir_steps.push_back(cfg_step(CFG_VEL_BYTE, 16'hFFFF));
        dir_steps.push_back(cfg_step(CFG_HOLD_MS, 16'd0));
        dir_steps.push_back(typed_step(7, 7, 1'b1, 32'd10, 1'b0, none_pkt));
        dir_steps.push_back(typed_step(7, 7, 1'b1, 32'd10, 1'b0, none_pkt));
        dir_steps.push_back(typed_step(7, 7, 1'b1, 32'd11, 1'b1,
                            kmd_out_t'{CIN_NOTE_ON, st_on_top, 8'd190, 7'd127}));
        dir_steps.push_back(typed_step(0, 1, 1'b1, 32'd50, 1'b0, none_pkt));
        dir_steps.push_back(typed_step(0, 1, 1'b1, 32'd51, 1'b1,
                            kmd_out_t'{CIN_NOTE_ON, st_on_top, 8'd128, 7'd127}));
        dir_steps.push_back(cfg_step(CFG_ROOT_KEY, 16'd0));
        dir_steps.push_back(cfg_step(CFG_CHAN_NUM, 16'd0));
        dir_steps.push_back(cfg_step(CFG_VEL_BYTE, 16'd0));
        dir_steps.push_back(cfg_step(CFG_HOLD_MS, 16'hFFFF));
        dir_steps.push_back(typed_step(2, 3, 1'b1, 32'd0, 1'b0, none_pkt));
        dir_steps.push_back(typed_step(2, 3, 1'b1, 32'd65535, 1'b0, none_pkt));
        dir_steps.push_back(typed_step(2, 3, 1'b1, 32'd65536, 1'b1,
                            kmd_out_t'{CIN_NOTE_ON, st_on_top, 8'd19, 7'd0}));
        dir_steps.push_back(typed_step(2, 3, 1'b0, 32'd70000, 1'b0, none_pkt));
        dir_steps.push_back(typed_step(2, 3, 1'b0, 32'd135536, 1'b1,
                            kmd_out_t'{CIN_NOTE_OFF, st_off_top, 8'd19, 7'd0}));

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        setting_cnt = 1;

        in_write = 1'b0;
        foreach (dir_steps[i]) begin
            if (dir_steps[i].is_write) begin
                if (!in_write) begin
                    settle_idle();
                    setting_cnt++;
                end
                in_write = 1'b1;
                write_reg(dir_steps[i].reg_idx, dir_steps[i].reg_val);
            end else begin
                in_write = 1'b0;
                send_sample(dir_steps[i].smp, dir_steps[i].typed, dir_steps[i].has_note,
                            dir_steps[i].note);
            end
        end
        dir_cnt = sent_cnt;

        for (int ph = 0; ph < 4; ph++) begin
            settle_idle();
            setting_cnt++;
            rnd = $urandom;
            write_reg(CFG_ROOT_KEY, rnd[15:0]);
            rnd = (ph == 2) ? ($urandom_range(17, 31) | ($urandom & 32'h0000_FFE0)) : $urandom;
            write_reg(CFG_CHAN_NUM, rnd[15:0]);
            rnd = $urandom;
            write_reg(CFG_VEL_BYTE, rnd[15:0]);
            case (ph)
                0: rnd = 32'd0;
                1: rnd = 32'h0000_FFFF;
                2: rnd = $urandom_range(1, 40);
                default: rnd = $urandom_range(0, 255);
            endcase
            write_reg(CFG_HOLD_MS, rnd[15:0]);
            if (ph == 2)
                hold_arm <= 1'b1;
            clk_ms = (ph == 1) ? (32'hFFFF_FFFF - $urandom_range(0, 2000000)) : $urandom;
            goal = sent_cnt + PHASE_ITEMS;

            while (sent_cnt < goal) begin
                key   = $urandom_range(0, NUM_KEYS - 1);
                other = $urandom_range(0, NUM_KEYS - 1);
                pick  = $urandom_range(0, 99);
                if (pick < 70) begin
                    lvl = !key_debounced[key];
                    send_sample(key_sample(key / KEY_COLS, key % KEY_COLS, lvl, clk_ms),
                                1'b0, 1'b0, none_pkt);
                    if (pick < 12) begin
                        clk_ms = clk_ms + $urandom_range(0, debounce_r);
                        send_sample(key_sample(key / KEY_COLS, key % KEY_COLS, !lvl, clk_ms),
                                    1'b0, 1'b0, none_pkt);
                        clk_ms = clk_ms + 32'd1;
                        send_sample(key_sample(key / KEY_COLS, key % KEY_COLS, lvl, clk_ms),
                                    1'b0, 1'b0, none_pkt);
                    end else if (pick < 30) begin
                        send_sample(key_sample(other / KEY_COLS, other % KEY_COLS,
                                               1'($urandom_range(0, 1)), clk_ms),
                                    1'b0, 1'b0, none_pkt);
                    end
                    clk_ms = clk_ms + debounce_r + $urandom_range(0, 2);
                    send_sample(key_sample(key / KEY_COLS, key % KEY_COLS, lvl, clk_ms),
                                1'b0, 1'b0, none_pkt);
                end else if (pick < 90) begin
                    send_sample(key_sample(other / KEY_COLS, other % KEY_COLS,
                                           1'($urandom_range(0, 1)),
                                           clk_ms + $urandom_range(0, 2 * debounce_r + 2)),
                                1'b0, 1'b0, none_pkt);
                end else begin
                    send_sample(key_sample(other / KEY_COLS, other % KEY_COLS,
                                           1'($urandom_range(0, 1)), $urandom),
                                1'b0, 1'b0, none_pkt);
                end
                clk_ms = clk_ms + $urandom_range(0, 3);
            end
        end

        settle_idle();
        $display("run covered %0d key samples (%0d directed) and %0d note packets",
                 sent_cnt, dir_cnt, note_cnt);
        $display("over %0d register settings, including a %0d-cycle output hold-off",
                 setting_cnt, HOLD_CYCLES);
        if (fail_cnt == 0) begin
            $display("tb_key_matrix_debounce_note_events_core passed");
        end else begin
            $display("tb_key_matrix_debounce_note_events_core failed");
        end
        $finish;
    end

endmodule
